// ===== rtl/smp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smp_pkg: shared types and constants of the square matrix power block
// Field widths, request codes, pass kinds, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package smp_pkg;

    // Entry arithmetic width (wraps modulo 2^DATA_W)
    localparam int DATA_W = 32;

    // Transaction field widths
    localparam int ROW_W   = 3;
    localparam int COL_W   = 3;
    localparam int VALUE_W = 32;
    localparam int EXP_W   = 31;
    localparam int SIZE_W  = 4;

    // Packed stream widths, padded to whole bytes
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 40;

    // Reset value of the size register
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    // Request kinds carried in tuser
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_START = 1'b1;

    // Sweep kinds run by the datapath
    typedef enum logic [2:0] {
        PASS_INIT,
        PASS_MUL_ACC,
        PASS_COPY_ACC,
        PASS_MUL_SQ,
        PASS_COPY_SQ,
        PASS_OUT
    } pass_kind_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_MUL_ACC,
        ST_COPY_ACC,
        ST_MUL_SQ,
        ST_COPY_SQ,
        ST_OUT
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic       start;
        pass_kind_t kind;
        logic       load;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic done;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/smp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents have no reset.
// ----------------------------------------------------------------------------
module smp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write on enable, read every cycle into the output register
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== rtl/smp_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smp_datapath: stores, sweep address generator and multiply-accumulate
// Holds the size register, the base, square, accumulator and product
// stores, runs one sweep per command and drives the output register.
// ----------------------------------------------------------------------------
module smp_datapath #(
    parameter int MAX_N = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [smp_pkg::SIZE_W-1:0]         cfg_wdata,
    input  wire logic [smp_pkg::ROW_W-1:0]          row,
    input  wire logic [smp_pkg::COL_W-1:0]          col,
    input  wire logic [smp_pkg::VALUE_W-1:0]        value,
    input  wire smp_pkg::dp_cmd_t                   cmd,
    output smp_pkg::dp_status_t                     status,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic      [smp_pkg::ROW_W-1:0]          out_row,
    output logic      [smp_pkg::COL_W-1:0]          out_col,
    output logic      [smp_pkg::VALUE_W-1:0]        out_value,
    output logic                                    out_last
);

    import smp_pkg::*;

    localparam int CNT_W = $clog2(MAX_N + 1);
    localparam int DEPTH = MAX_N * MAX_N;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Size register and effective size
    logic [SIZE_W-1:0] size_reg;
    logic [CNT_W-1:0]  n_eff;
    logic [CNT_W-1:0]  n_last;

    // Base store valid bits
    logic [DEPTH-1:0] base_vld_reg;
    logic [DEPTH-1:0] base_vld_next;
    logic             base_we;
    logic [IDX_W-1:0] load_idx;

    // Sweep control
    logic             run_reg, run_next;
    logic             busy_reg, busy_next;
    pass_kind_t       kind_reg, kind_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             mul_kind;
    logic             k_end, j_end, i_end;
    logic             advance;
    logic             done;

    // Addresses
    logic [IDX_W-1:0] idx_ij, idx_ik, idx_kj;

    // Read stage
    logic             s1_valid_reg;
    logic             s1_first_reg;
    logic             s1_last_reg;
    logic             s1_end_reg;
    logic             s1_bvld_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic [CNT_W-1:0] s1_row_reg;
    logic [CNT_W-1:0] s1_col_reg;

    // Multiply stage
    logic              s2_valid_reg;
    logic              s2_first_reg;
    logic              s2_last_reg;
    logic [IDX_W-1:0]  s2_idx_reg;
    logic [DATA_W-1:0] s2_prod_reg;
    logic [DATA_W-1:0] sum_reg;
    logic [DATA_W-1:0] sum_next;

    // RAM ports
    logic [DATA_W-1:0] base_rd, acc_rd, sq_a_rd, sq_b_rd, prod_rd;
    logic [IDX_W-1:0]  acc_raddr;
    logic              acc_we, sq_we;
    logic [IDX_W-1:0]  acc_waddr, sq_waddr;
    logic [DATA_W-1:0] acc_wdata, sq_wdata;
    logic [DATA_W-1:0] base_data;
    logic [DATA_W-1:0] a_data;
    logic [DATA_W-1:0] mul_low;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [ROW_W-1:0]   out_row_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_last_reg;
    logic               load_out;

    // Hold the size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            size_reg <= cfg_wdata;
        end
    end

    // Clamp size to 1..MAX_N
    always_comb
    begin
        if (size_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (32'(size_reg) > 32'(MAX_N))
        begin
            n_eff = CNT_W'(MAX_N);
        end
        else
        begin
            n_eff = CNT_W'(size_reg);
        end
    end

    assign n_last = n_eff - CNT_W'(1);

    // Accept a load only inside the active size
    assign base_we  = cmd.load && (32'(row) < 32'(n_eff)) && (32'(col) < 32'(n_eff));
    assign load_idx = IDX_W'(32'(row) * 32'(MAX_N) + 32'(col));

    always_comb
    begin
        base_vld_next = base_vld_reg;
        if (base_we)
        begin
            base_vld_next[load_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_vld_reg <= '0;
        end
        else
        begin
            base_vld_reg <= base_vld_next;
        end
    end

    // Sweep limits and stall
    assign mul_kind = (kind_reg == PASS_MUL_ACC) || (kind_reg == PASS_MUL_SQ);
    assign k_end    = !mul_kind || (k_reg == n_last);
    assign j_end    = (j_reg == n_last);
    assign i_end    = (i_reg == n_last);
    assign advance  = run_reg && ((kind_reg != PASS_OUT) ||
                      (!s1_valid_reg && (!out_valid_reg || out_ready)));
    assign done     = busy_reg && !run_reg && !s1_valid_reg && !s2_valid_reg;

    assign status.done = done;

    // Advance the i, j, k counters
    always_comb
    begin
        run_next  = run_reg;
        busy_next = busy_reg;
        kind_next = kind_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        k_next    = k_reg;
        if (cmd.start)
        begin
            run_next  = 1'b1;
            busy_next = 1'b1;
            kind_next = cmd.kind;
            i_next    = '0;
            j_next    = '0;
            k_next    = '0;
        end
        else
        begin
            if (done)
            begin
                busy_next = 1'b0;
            end
            if (advance)
            begin
                if (!k_end)
                begin
                    k_next = k_reg + CNT_W'(1);
                end
                else
                begin
                    k_next = '0;
                    if (!j_end)
                    begin
                        j_next = j_reg + CNT_W'(1);
                    end
                    else
                    begin
                        j_next = '0;
                        if (!i_end)
                        begin
                            i_next = i_reg + CNT_W'(1);
                        end
                        else
                        begin
                            i_next   = '0;
                            run_next = 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            busy_reg <= 1'b0;
            kind_reg <= PASS_INIT;
            i_reg    <= '0;
            j_reg    <= '0;
            k_reg    <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            busy_reg <= busy_next;
            kind_reg <= kind_next;
            i_reg    <= i_next;
            j_reg    <= j_next;
            k_reg    <= k_next;
        end
    end

    // Form row-major store indexes
    assign idx_ij = IDX_W'(32'(i_reg) * 32'(MAX_N) + 32'(j_reg));
    assign idx_ik = IDX_W'(32'(i_reg) * 32'(MAX_N) + 32'(k_reg));
    assign idx_kj = IDX_W'(32'(k_reg) * 32'(MAX_N) + 32'(j_reg));

    assign acc_raddr = (kind_reg == PASS_OUT) ? idx_ij : idx_ik;

    // Read stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= advance;
            s2_valid_reg <= s1_valid_reg && mul_kind;
        end
    end

    // Carry sweep position along with the reads
    always_ff @(posedge clk)
    begin
        s1_first_reg <= (k_reg == '0);
        s1_last_reg  <= k_end;
        s1_end_reg   <= i_end && j_end;
        s1_bvld_reg  <= base_vld_reg[idx_ij];
        s1_idx_reg   <= idx_ij;
        s1_row_reg   <= i_reg;
        s1_col_reg   <= j_reg;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_idx_reg   <= s1_idx_reg;
        s2_prod_reg  <= mul_low;
        if (s2_valid_reg)
        begin
            sum_reg <= sum_next;
        end
    end

    // Multiply one pair of entries
    assign base_data = s1_bvld_reg ? base_rd : '0;
    assign a_data    = (kind_reg == PASS_MUL_ACC) ? acc_rd : sq_a_rd;
    assign mul_low   = DATA_W'(a_data * sq_b_rd);

    // Accumulate the dot product
    assign sum_next = s2_first_reg ? s2_prod_reg : (sum_reg + s2_prod_reg);

    // Route writes into the accumulator and square stores
    always_comb
    begin
        acc_we    = 1'b0;
        acc_waddr = s1_idx_reg;
        acc_wdata = prod_rd;
        sq_we     = 1'b0;
        sq_waddr  = s1_idx_reg;
        sq_wdata  = prod_rd;
        case (kind_reg)
            PASS_INIT:
            begin
                acc_we    = advance;
                acc_waddr = idx_ij;
                acc_wdata = (i_reg == j_reg) ? DATA_W'(1) : '0;
                sq_we     = s1_valid_reg;
                sq_wdata  = base_data;
            end
            PASS_COPY_ACC:
            begin
                acc_we = s1_valid_reg;
            end
            PASS_COPY_SQ:
            begin
                sq_we = s1_valid_reg;
            end
            default:
            begin
                acc_we = 1'b0;
                sq_we  = 1'b0;
            end
        endcase
    end

    smp_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_base_ram (
        .clk     (clk),
        .wr_en   (base_we),
        .wr_addr (load_idx),
        .wr_data (DATA_W'(value)),
        .rd_addr (idx_ij),
        .rd_data (base_rd)
    );

    smp_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_acc_ram (
        .clk     (clk),
        .wr_en   (acc_we),
        .wr_addr (acc_waddr),
        .wr_data (acc_wdata),
        .rd_addr (acc_raddr),
        .rd_data (acc_rd)
    );

    // Square store, duplicated to give the row and column reads of a squaring
    smp_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_sq_a_ram (
        .clk     (clk),
        .wr_en   (sq_we),
        .wr_addr (sq_waddr),
        .wr_data (sq_wdata),
        .rd_addr (idx_ik),
        .rd_data (sq_a_rd)
    );

    smp_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_sq_b_ram (
        .clk     (clk),
        .wr_en   (sq_we),
        .wr_addr (sq_waddr),
        .wr_data (sq_wdata),
        .rd_addr (idx_kj),
        .rd_data (sq_b_rd)
    );

    smp_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_prod_ram (
        .clk     (clk),
        .wr_en   (s2_valid_reg && s2_last_reg),
        .wr_addr (s2_idx_reg),
        .wr_data (sum_next),
        .rd_addr (idx_ij),
        .rd_data (prod_rd)
    );

    // Load the output register, drop it once taken
    assign load_out = s1_valid_reg && (kind_reg == PASS_OUT);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_row_reg   <= ROW_W'(s1_row_reg);
            out_col_reg   <= COL_W'(s1_col_reg);
            out_value_reg <= VALUE_W'(acc_rd);
            out_last_reg  <= s1_end_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

endmodule
`default_nettype wire

// ===== rtl/smp_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smp_controller: pass sequencer for exponentiation by squaring
// Takes requests, walks the exponent bits and commands one datapath
// sweep at a time: initialise, multiply, copy back, emit.
// ----------------------------------------------------------------------------
module smp_controller (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      req_type,
    input  wire logic [smp_pkg::EXP_W-1:0] exponent,
    input  wire smp_pkg::dp_status_t       status,
    output smp_pkg::dp_cmd_t               cmd
);

    import smp_pkg::*;

    ctrl_state_t      state_reg, state_next;
    logic [EXP_W-1:0] exp_reg, exp_next;
    logic             accept;

    assign accept = in_valid && (state_reg == ST_IDLE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == REQ_START))
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (status.done)
                begin
                    if (exp_reg == '0)
                    begin
                        state_next = ST_OUT;
                    end
                    else if (exp_reg[0])
                    begin
                        state_next = ST_MUL_ACC;
                    end
                    else
                    begin
                        state_next = ST_MUL_SQ;
                    end
                end
            end
            ST_MUL_ACC:
            begin
                if (status.done)
                begin
                    state_next = ST_COPY_ACC;
                end
            end
            ST_COPY_ACC:
            begin
                // Skip the squaring once no higher bit is left
                if (status.done)
                begin
                    if (exp_reg[EXP_W-1:1] == '0)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_MUL_SQ;
                    end
                end
            end
            ST_MUL_SQ:
            begin
                if (status.done)
                begin
                    state_next = ST_COPY_SQ;
                end
            end
            ST_COPY_SQ:
            begin
                // Look at the next exponent bit
                if (status.done)
                begin
                    if (exp_reg[1])
                    begin
                        state_next = ST_MUL_ACC;
                    end
                    else
                    begin
                        state_next = ST_MUL_SQ;
                    end
                end
            end
            ST_OUT:
            begin
                if (status.done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Capture the exponent, shift it after each squaring
    always_comb
    begin
        exp_next = exp_reg;
        if (accept && (req_type == REQ_START))
        begin
            exp_next = exponent;
        end
        else if ((state_reg == ST_COPY_SQ) && status.done)
        begin
            exp_next = exp_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            exp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            exp_reg   <= exp_next;
        end
    end

    // Outputs: ready, load strobe and sweep launch
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        cmd.load  = accept && (req_type == REQ_LOAD);
        cmd.start = (state_next != state_reg) && (state_next != ST_IDLE);
        case (state_next)
            ST_INIT:     cmd.kind = PASS_INIT;
            ST_MUL_ACC:  cmd.kind = PASS_MUL_ACC;
            ST_COPY_ACC: cmd.kind = PASS_COPY_ACC;
            ST_MUL_SQ:   cmd.kind = PASS_MUL_SQ;
            ST_COPY_SQ:  cmd.kind = PASS_COPY_SQ;
            ST_OUT:      cmd.kind = PASS_OUT;
            default:     cmd.kind = PASS_INIT;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/square_matrix_power.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// square_matrix_power: integer matrix raised to a power by squaring
//
//   Channel  Direction  Handshake          Contents
//   cfg      in         cfg_we             size_in_use (cfg_wdata)
//   s        in         s_tvalid/s_tready  load one entry or start a power
//   m        out        m_tvalid/m_tready  result entries, row-major, tlast
//
// A start initialises, then runs one matrix product per exponent one bit
// and one squaring per higher bit, and then emits the result; the single
// multiply-accumulate unit takes one entry pair a cycle.
// Reset clears the base store at once through per-entry valid bits.
// s_tready is low from a start until the last result sits in the output
// register; m_tready low holds the output sweep with the entry held there.
// ----------------------------------------------------------------------------
module square_matrix_power #(
    parameter int MAX_N = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Size register
    input  wire logic                             cfg_we,
    input  wire logic [smp_pkg::SIZE_W-1:0]       cfg_wdata,
    // Requests
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // row[2:0], col[5:3], value[37:6], exponent[68:38], zero pad[71:69]
    input  wire logic [smp_pkg::IN_DATA_W-1:0]    s_tdata,
    // req_type[0]
    input  wire logic                             s_tuser,
    // Results
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // out_row[2:0], out_col[5:3], out_value[37:6], zero pad[39:38]
    output logic      [smp_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                                  m_tlast
);

    import smp_pkg::*;

    localparam int ROW_LO   = 0;
    localparam int COL_LO   = ROW_LO + ROW_W;
    localparam int VALUE_LO = COL_LO + COL_W;
    localparam int EXP_LO   = VALUE_LO + VALUE_W;
    localparam int OUT_PAD  = OUT_DATA_W - ROW_W - COL_W - VALUE_W;

    dp_cmd_t            cmd;
    dp_status_t         status;
    logic [ROW_W-1:0]   out_row;
    logic [COL_W-1:0]   out_col;
    logic [VALUE_W-1:0] out_value;

    smp_controller u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .req_type (s_tuser),
        .exponent (s_tdata[EXP_LO +: EXP_W]),
        .status   (status),
        .cmd      (cmd)
    );

    smp_datapath #(.MAX_N(MAX_N)) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .row       (s_tdata[ROW_LO +: ROW_W]),
        .col       (s_tdata[COL_LO +: COL_W]),
        .value     (s_tdata[VALUE_LO +: VALUE_W]),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_value (out_value),
        .out_last  (m_tlast)
    );

    // Pack the result transaction
    assign m_tdata = {OUT_PAD'(0), out_value, out_col, out_row};

    // A start closes the request channel in the next cycle
    a_start_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == REQ_START)) |=> !s_tready)
        else $error("request channel still open after a start");

    // A load leaves the block ready for the next request
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == REQ_LOAD)) |=> s_tready)
        else $error("request channel closed after a load");

    // Sweep completion is a single-cycle event
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        status.done |=> !status.done)
        else $error("sweep completion held for more than one cycle");

    // Initialisation is launched only by an accepted start
    a_start_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start && (cmd.kind == PASS_INIT)) |-> (s_tvalid && s_tready))
        else $error("initialisation launched without a start request");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for square_matrix_power
// Loads base entries and starts powers over the request stream, across
// matrix sizes from one to the maximum and exponents up to the full field.
// Every accepted request is applied to a behavioural copy of the block,
// and each result transaction is checked against the oldest expected entry.
// The sender runs in bursts and the receiver stalls, once for a long spell.
// ----------------------------------------------------------------------------
module testbench;
    import smp_pkg::*;

    localparam int MAX_N = 8;
    localparam int CELLS = MAX_N * MAX_N;
    localparam int unsigned CYCLE_LIMIT = 20_000_000;
    localparam int RANDOM_ITEMS = 170;
    localparam int HOLD_CYCLES = 3000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS = 20;
    localparam int MAX_BIG_STARTS = 6;
    localparam int DIRECTED_STEPS = 28;

    typedef enum logic [1:0] {
        STEP_LOAD,
        STEP_START,
        STEP_SIZE
    } step_kind_t;

    // One row of the directed plan; value holds the new size on STEP_SIZE
    typedef struct packed {
        step_kind_t           kind;
        logic [ROW_W-1:0]     row;
        logic [COL_W-1:0]     col;
        logic [VALUE_W-1:0]   value;
        logic [EXP_W-1:0]     exponent;
        logic                 typed;
        logic [DATA_W-1:0]    diag;
        logic [DATA_W-1:0]    off_diag;
    } step_t;

    typedef struct packed {
        logic [ROW_W-1:0]     row;
        logic [COL_W-1:0]     col;
        logic [DATA_W-1:0]    value;
        logic                 last;
    } power_entry_t;

    // Directed plan: typed rows give the whole result as diagonal and off-diagonal
    localparam step_t DIRECTED_PLAN [DIRECTED_STEPS] = '{
        '{STEP_START, 3'd0, 3'd0, 32'd0,          31'd0,          1'b1, 32'd1, 32'd0},
        '{STEP_START, 3'd0, 3'd0, 32'd0,          31'd1,          1'b1, 32'd0, 32'd0},
        '{STEP_START, 3'd0, 3'd0, 32'd0,          31'h7FFF_FFFF,  1'b1, 32'd0, 32'd0},
        '{STEP_LOAD,  3'd7, 3'd7, 32'hFFFF_FFFF,  31'd0,          1'b0, 32'd0, 32'd0},
        '{STEP_LOAD,  3'd0, 3'd0, 32'h0000_0002,  31'd0,          1'b0, 32'd0, 32'd0},
        '{STEP_LOAD,  3'd0, 3'd7, 32'hAAAA_AAAA,  31'd0,          1'b0, 32'd0, 32'd0},
        '{STEP_LOAD,  3'd7, 3'd0, 32'h5555_5555,  31'd0,          1'b0, 32'd0, 32'd0},
        '{STEP_LOAD,  3'd3, 3'd4, 32'h8000_0001,  31'd0,          1'b0, 32'd0, 32'd0},
        '{STEP_LOAD,  3'd1, 3'd1, 32'h0000_0000,  31'd0,          1'b0, 32'd0, 32'd0},
        '{STEP_START, 3'd0, 3'd0, 32'd0,          31'd2,          1'b0, 32'd0, 32'd0},
        '{STEP_START, 3'd0, 3'd0, 32'd0,          31'h7FFF_FFFF,  1'b0, 32'd0, 32'd0},
        '{STEP_SIZE,  3'd0, 3'd0, 32'd0,          31'd0,          1'b0, 32'd0, 32'd0},
        '{STEP_LOAD,  3'd1, 3'd0, 32'd5,          31'd0,          1'b0, 32'd0, 32'd0},
        '{STEP_LOAD,  3'd0, 3'd1, 32'd6,          31'd0,          1'b0, 32'd0, 32'd0},
        '{STEP_LOAD,  3'd0, 3'd0, 32'd3,          31'd0,          1'b0, 32'd0, 32'd0},
        '{STEP_START, 3'd0, 3'd0, 32'd0,          31'h7FFF_FFFF,  1'b0, 32'd0, 32'd0},
        '{STEP_START, 3'd0, 3'd0, 32'd0,          31'd0,          1'b1, 32'd1, 32'd0},
        '{STEP_SIZE,  3'd0, 3'd0, 32'd15,         31'd0,          1'b0, 32'd0, 32'd0},
        '{STEP_START, 3'd0, 3'd0, 32'd0,          31'd3,          1'b0, 32'd0, 32'd0},
        '{STEP_SIZE,  3'd0, 3'd0, 32'd2,          31'd0,          1'b0, 32'd0, 32'd0},
        '{STEP_LOAD,  3'd0, 3'd0, 32'd1,          31'd0,          1'b0, 32'd0, 32'd0},
        '{STEP_LOAD,  3'd0, 3'd1, 32'd1,          31'd0,          1'b0, 32'd0, 32'd0},
        '{STEP_LOAD,  3'd1, 3'd0, 32'd1,          31'd0,          1'b0, 32'd0, 32'd0},
        '{STEP_LOAD,  3'd1, 3'd1, 32'd0,          31'd0,          1'b0, 32'd0, 32'd0},
        '{STEP_LOAD,  3'd2, 3'd2, 32'd9,          31'd0,          1'b0, 32'd0, 32'd0},
        '{STEP_START, 3'd0, 3'd0, 32'd0,          31'd40,         1'b0, 32'd0, 32'd0},
        '{STEP_SIZE,  3'd0, 3'd0, 32'd1,          31'd0,          1'b0, 32'd0, 32'd0},
        '{STEP_START, 3'd0, 3'd0, 32'd0,          31'd5,          1'b0, 32'd0, 32'd0}
    };

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_we;
    logic [SIZE_W-1:0]        cfg_wdata;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_DATA_W-1:0]     s_tdata;
    logic                     s_tuser;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]    m_tdata;
    logic                     m_tlast;

    // Sideband travelling with the offered request: typed result, if any
    logic                     typed_result = 1'b0;
    logic [DATA_W-1:0]        typed_diag = '0;
    logic [DATA_W-1:0]        typed_off = '0;

    // Behavioural copy of the block
    logic [DATA_W-1:0]        base_copy [CELLS];
    logic [SIZE_W-1:0]        size_copy = SIZE_RESET;
    logic [DATA_W-1:0]        power_mat [CELLS];
    power_entry_t             power_entries_q [$];

    int                       mismatches = 0;
    int unsigned              cycle_count = 0;
    int                       burst_left = 0;
    int                       hold_req = 0;
    int                       hold_seen = 0;
    int                       hold_left = 0;
    int                       rx_mode = 0;
    int                       rx_left = 0;
    logic [3:0]               rx_phase = '0;

    square_matrix_power #(
        .MAX_N(MAX_N)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Size register as the block sees it: zero means one, saturate at MAX_N
    function automatic int span_of(input logic [SIZE_W-1:0] size_val);
        if (size_val == 0)
            return 1;
        if (size_val > MAX_N)
            return MAX_N;
        return int'(size_val);
    endfunction

    // Raise the base copy to the exponent by squaring, into power_mat
    function automatic void compute_power(input int n, input logic [EXP_W-1:0] exponent);
        logic [DATA_W-1:0] square [CELLS];
        logic [DATA_W-1:0] scratch [CELLS];
        logic [DATA_W-1:0] sum;
        logic [EXP_W-1:0]  bits_left;
        bits_left = exponent;
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
            begin
                power_mat[i * MAX_N + j] = (i == j) ? 1 : 0;
                square[i * MAX_N + j] = base_copy[i * MAX_N + j];
            end
        while (bits_left != 0)
        begin
            // first multiply the running square in, then square it
            for (int pass = 0; pass < 2; pass++)
            begin
                if (pass == 0 && !bits_left[0])
                    continue;
                for (int i = 0; i < n; i++)
                    for (int j = 0; j < n; j++)
                    begin
                        sum = '0;
                        for (int k = 0; k < n; k++)
                            sum += ((pass == 0) ? power_mat[i * MAX_N + k]
                                                : square[i * MAX_N + k])
                                   * square[k * MAX_N + j];
                        scratch[i * MAX_N + j] = sum;
                    end
                for (int i = 0; i < n; i++)
                    for (int j = 0; j < n; j++)
                        if (pass == 0)
                            power_mat[i * MAX_N + j] = scratch[i * MAX_N + j];
                        else
                            square[i * MAX_N + j] = scratch[i * MAX_N + j];
            end
            bits_left = bits_left >> 1;
        end
    endfunction

    // Entry values: mostly small so powers stay readable, some full width
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0, 1, 2: return VALUE_W'($urandom_range(0, 3));
            3:       return $urandom_range(0, 1) ? '1 : '0;
            default: return $urandom;
        endcase
    endfunction

    // Offer one request, after a gap when a new burst begins, and hold until accepted
    task automatic offer_request(input logic req, input logic [ROW_W-1:0] row,
                                 input logic [COL_W-1:0] col,
                                 input logic [VALUE_W-1:0] value,
                                 input logic [EXP_W-1:0] exponent,
                                 input logic typed, input logic [DATA_W-1:0] diag,
                                 input logic [DATA_W-1:0] off_diag);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 48)
                                                     : $urandom_range(1, 6);
        end
        burst_left--;
        s_tvalid     <= 1'b1;
        s_tuser      <= req;
        s_tdata      <= {3'b000, exponent, value, col, row};
        typed_result <= typed;
        typed_diag   <= diag;
        typed_off    <= off_diag;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Load outside the size in use, which the block drops
    task automatic offer_ignored_load(input int n);
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        row = ROW_W'($urandom_range(0, MAX_N - 1));
        col = COL_W'($urandom_range(0, MAX_N - 1));
        if ($urandom_range(0, 1))
            row = ROW_W'($urandom_range(n, MAX_N - 1));
        else
            col = COL_W'($urandom_range(n, MAX_N - 1));
        offer_request(REQ_LOAD, row, col, $urandom, '0, 1'b0, '0, '0);
    endtask

    // Drop the request stream, wait for every result and let the last load settle
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (power_entries_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] size_val);
        cfg_we    <= 1'b1;
        cfg_wdata <= size_val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Track accepted transactions and check results
    always @(posedge clk)
    begin : track
        int n;
        power_entry_t got;
        power_entry_t want;
        if (rst_n)
        begin
            if (cfg_we)
                size_copy = cfg_wdata;
            n = span_of(size_copy);

            if (s_tvalid && s_tready)
            begin
                if (s_tuser == REQ_LOAD)
                begin
                    if (s_tdata[2:0] < n && s_tdata[5:3] < n)
                        base_copy[s_tdata[2:0] * MAX_N + s_tdata[5:3]] = s_tdata[37:6];
                end
                else
                begin
                    if (typed_result)
                    begin
                        for (int i = 0; i < n; i++)
                            for (int j = 0; j < n; j++)
                                power_mat[i * MAX_N + j] = (i == j) ? typed_diag : typed_off;
                    end
                    else
                        compute_power(n, s_tdata[68:38]);
                    for (int i = 0; i < n; i++)
                        for (int j = 0; j < n; j++)
                        begin
                            want.row   = ROW_W'(i);
                            want.col   = COL_W'(j);
                            want.value = power_mat[i * MAX_N + j];
                            want.last  = (i == n - 1 && j == n - 1);
                            power_entries_q.push_back(want);
                        end
                end
            end

            if (m_tvalid && m_tready)
            begin
                got.row   = m_tdata[2:0];
                got.col   = m_tdata[5:3];
                got.value = m_tdata[37:6];
                got.last  = m_tlast;
                if (power_entries_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, ", $time,
                                 "actual row %0d col %0d value %h last %b",
                                 got.row, got.col, got.value, got.last);
                end
                else
                begin
                    want = power_entries_q.pop_front();
                    if (got.row !== want.row || got.col !== want.col ||
                        got.value !== want.value || got.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: result mismatch, ", $time,
                                     "expected row %0d col %0d value %h last %b, ",
                                     want.row, want.col, want.value, want.last,
                                     "actual row %0d col %0d value %h last %b",
                                     got.row, got.col, got.value, got.last);
                    end
                end
            end
        end
    end

    // Receiver: stall patterns of its own, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_seen != hold_req && m_tvalid)
        begin
            m_tready  <= 1'b0;
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        else
        begin
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (rx_phase[2:0] < 3'd3);
            endcase
        end
        rx_phase <= rx_phase + 1'b1;
        if (rx_left == 0)
        begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(20, 300);
        end
        else
            rx_left <= rx_left - 1;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : stimulus
        step_t            step;
        logic [SIZE_W-1:0] cur_size;
        logic [EXP_W-1:0] exponent;
        int               n;
        int               phase;
        int               count;
        int               sel;
        int               random_items;
        int               big_starts;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tuser   = REQ_LOAD;
        s_tdata   = '0;
        for (int i = 0; i < CELLS; i++)
            base_copy[i] = '0;
        cur_size = SIZE_RESET;
        random_items = 0;
        big_starts = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed plan
        for (int i = 0; i < DIRECTED_STEPS; i++)
        begin
            step = DIRECTED_PLAN[i];
            case (step.kind)
                STEP_SIZE:
                begin
                    settle_idle();
                    cur_size = step.value[SIZE_W-1:0];
                    write_size(cur_size);
                end
                STEP_LOAD:
                    offer_request(REQ_LOAD, step.row, step.col, step.value, step.exponent,
                                  1'b0, '0, '0);
                default:
                    offer_request(REQ_START, step.row, step.col, step.value, step.exponent,
                                  step.typed, step.diag, step.off_diag);
            endcase
        end

        // Random phases: fill the base, with some noise, then start a power
        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            // keep the first two phases back to back so the long hold-off backs up
            if (phase >= 2 && $urandom_range(0, 2) == 0)
            begin
                sel = $urandom_range(0, 19);
                if (sel == 0)
                    cur_size = '0;
                else if (sel == 1)
                    cur_size = SIZE_W'($urandom_range(MAX_N + 1, 15));
                else if (sel < 5)
                    cur_size = SIZE_W'($urandom_range(5, MAX_N));
                else
                    cur_size = SIZE_W'($urandom_range(1, 4));
                settle_idle();
                write_size(cur_size);
            end
            n = span_of(cur_size);

            if ($urandom_range(0, 4) != 0)
            begin
                for (int r = 0; r < n; r++)
                    for (int c = 0; c < n; c++)
                    begin
                        if (n < MAX_N && $urandom_range(0, 7) == 0)
                            offer_ignored_load(n);
                        offer_request(REQ_LOAD, ROW_W'(r), COL_W'(c), pick_value(), '0,
                                      1'b0, '0, '0);
                        random_items++;
                    end
            end
            else
            begin
                // partial or scattered fill
                count = $urandom_range(0, n * n);
                for (int k = 0; k < count; k++)
                begin
                    if (n < MAX_N && $urandom_range(0, 3) == 0)
                        offer_ignored_load(n);
                    offer_request(REQ_LOAD, ROW_W'($urandom_range(0, n - 1)),
                                  COL_W'($urandom_range(0, n - 1)), pick_value(), '0,
                                  1'b0, '0, '0);
                    random_items++;
                end
            end

            // mostly short exponents; a few full-width ones
            sel = $urandom_range(0, 19);
            if (sel == 0 && big_starts < MAX_BIG_STARTS)
            begin
                exponent = EXP_W'($urandom);
                big_starts++;
            end
            else if (sel < 6)
                exponent = EXP_W'($urandom_range(0, 65535));
            else
                exponent = EXP_W'($urandom_range(0, 40));

            if (phase == 0)
                hold_req <= hold_req + 1;
            offer_request(REQ_START, '0, '0, $urandom, exponent, 1'b0, '0, '0);
            random_items++;
            phase++;
        end

        settle_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
